// File: hw/rtl/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants for the servo command frame builder.
// ----------------------------------------------------------------------------
package sbf_pkg;

    // input opcodes
    localparam logic [1:0] OP_PING  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // frame bytes
    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] INST_PING  = 8'h01;
    localparam logic [7:0] INST_READ  = 8'h02;
    localparam logic [7:0] INST_WRITE = 8'h03;
    localparam logic [7:0] LEN_PING   = 8'h02;
    localparam logic [7:0] LEN_READ   = 8'h04;

    // frame sizes in bytes
    localparam logic [9:0] SIZE_PING      = 10'd6;
    localparam logic [9:0] SIZE_READ      = 10'd8;
    localparam logic [9:0] SIZE_WRITE_MIN = 10'd7;

    localparam logic [8:0] CAP_RESET  = 9'd262;
    localparam int         FIFO_DEPTH = 4;

    // work passed from the front end to the byte serializer
    typedef enum logic [2:0] {
        K_PING,
        K_READ,
        K_WHDR,      // write header, data words follow
        K_WHDR_END,  // write header with zero count, checksum included
        K_DATA,
        K_DATA_LAST, // data byte followed by checksum
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] id;
        logic [7:0] len;
        logic [7:0] inst;
        logic [7:0] p0;
        logic [7:0] p1;
        logic [7:0] chk;
    } t_cmd;

endpackage

// File: hw/rtl/servo_command_frame_builder_top.sv
// ----------------------------------------------------------------------------
// servo_command_frame_builder_top
// Servo bus instruction frame builder (FF FF ID LEN INST PARAMS CHK).
//
// Input channel (i_in_valid / o_in_stall): one word per ping, read or
// write header, then one word per write data byte. A word is taken on a
// rising edge with valid high and stall low.
// Output channel (o_out_valid / i_out_stall): one frame byte per word,
// with o_frame_end on the checksum byte or a rejection word, o_rejected on
// a rejection (byte 0x00). Frames that exceed the capacity register are
// rejected and their data words are swallowed.
// Config channel (i_cfg_valid / o_cfg_ready): frame capacity, always ready,
// the user must write it only while idle; the block does not enforce this.
// An accepted item passes via the command queue to the output register.
// While fed and not stalled, the serializer emits one byte per cycle; a
// ping is 6 bytes, a read 8, a write header 6 (7 with zero count), a data
// word 1 (2 for the last one). The front end accepts one word per cycle
// while the command queue has room; output bytes set the sustained rate.
// Reset (synchronous, active low) empties the queue, drops any open write
// and sets the capacity to 262. A stalled output word holds, the queue
// fills, and o_in_stall rises when it is full.
// ----------------------------------------------------------------------------
module servo_command_frame_builder_top
    import sbf_pkg::*;
#(
    parameter int P_FIFO_DEPTH = FIFO_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input words
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_servo_id,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_data_byte,
    // output bytes
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_rejected,
    // capacity register
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data
);

    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd front_cmd;
    t_cmd head_cmd;

    // config always taken; writes must arrive only while idle, unchecked here
    assign o_cfg_ready = 1'b1;

    // stall depends only on queue occupancy
    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    // front end: classify word, update write/discard state
    sbf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid && o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_opcode     (i_opcode),
        .i_servo_id   (i_servo_id),
        .i_reg_addr   (i_reg_addr),
        .i_byte_count (i_byte_count),
        .i_data_byte  (i_data_byte),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    // decoupling queue
    sbf_cmd_fifo #(
        .DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // back end: byte serializer with output register
    sbf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_rejected  (o_rejected)
    );

endmodule

// File: hw/rtl/sbf_front.sv
// ----------------------------------------------------------------------------
// sbf_front
// Takes input words, tracks open/discarded write frames, builds commands.
// ----------------------------------------------------------------------------
module sbf_front
    import sbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data,
    input  logic       i_accept,
    input  logic [1:0] i_opcode,
    input  logic [7:0] i_servo_id,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_data_byte,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [8:0] r_capacity;
    logic       r_write_open, n_write_open;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_sum, n_sum;
    logic       r_discarding, n_discarding;

    logic [7:0] left_dec;
    logic [7:0] data_sum;
    logic [7:0] wr_len;
    logic [7:0] wr_sum;
    logic [9:0] cap_ext;

    assign left_dec = r_bytes_left - 8'd1;
    assign data_sum = r_sum + i_data_byte;
    assign wr_len   = i_byte_count + 8'd3;
    assign wr_sum   = i_servo_id + wr_len + INST_WRITE + i_reg_addr;
    assign cap_ext  = {1'b0, r_capacity};

    always_comb begin
        n_write_open = r_write_open;
        n_bytes_left = r_bytes_left;
        n_sum        = r_sum;
        n_discarding = r_discarding;
        o_push       = 1'b0;
        o_cmd.kind   = K_REJECT;
        o_cmd.id     = i_servo_id;
        o_cmd.len    = LEN_PING;
        o_cmd.inst   = INST_PING;
        o_cmd.p0     = i_reg_addr;
        o_cmd.p1     = i_byte_count;
        o_cmd.chk    = ~(i_servo_id + LEN_PING + INST_PING);

        if (r_discarding) begin
            n_bytes_left = left_dec;
            if (left_dec == 8'd0) begin
                n_discarding = 1'b0;
            end
        end else if (r_write_open) begin
            o_push       = 1'b1;
            n_sum        = data_sum;
            n_bytes_left = left_dec;
            o_cmd.p0     = i_data_byte;
            o_cmd.chk    = ~data_sum;
            if (left_dec == 8'd0) begin
                o_cmd.kind   = K_DATA_LAST;
                n_write_open = 1'b0;
            end else begin
                o_cmd.kind = K_DATA;
            end
        end else begin
            unique case (i_opcode)
                OP_PING: begin
                    o_push = 1'b1;
                    o_cmd.kind = (cap_ext < SIZE_PING) ? K_REJECT : K_PING;
                end
                OP_READ: begin
                    o_push     = 1'b1;
                    o_cmd.len  = LEN_READ;
                    o_cmd.inst = INST_READ;
                    o_cmd.chk  = ~(i_servo_id + LEN_READ + INST_READ + i_reg_addr
                                   + i_byte_count);
                    o_cmd.kind = (cap_ext < SIZE_READ) ? K_REJECT : K_READ;
                end
                OP_WRITE: begin
                    o_push     = 1'b1;
                    o_cmd.len  = wr_len;
                    o_cmd.inst = INST_WRITE;
                    o_cmd.chk  = ~wr_sum;
                    if (cap_ext < SIZE_WRITE_MIN + {2'b00, i_byte_count}) begin
                        o_cmd.kind = K_REJECT;
                        if (i_byte_count != 8'd0) begin
                            n_discarding = 1'b1;
                            n_bytes_left = i_byte_count;
                        end
                    end else begin
                        n_sum = wr_sum;
                        if (i_byte_count == 8'd0) begin
                            o_cmd.kind = K_WHDR_END;
                        end else begin
                            o_cmd.kind   = K_WHDR;
                            n_write_open = 1'b1;
                            n_bytes_left = i_byte_count;
                        end
                    end
                end
                OP_NONE: begin
                    o_push = 1'b0;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end

        if (!i_accept) begin
            o_push       = 1'b0;
            n_write_open = r_write_open;
            n_bytes_left = r_bytes_left;
            n_sum        = r_sum;
            n_discarding = r_discarding;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity   <= CAP_RESET;
            r_write_open <= 1'b0;
            r_bytes_left <= 8'd0;
            r_sum        <= 8'd0;
            r_discarding <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            r_write_open <= n_write_open;
            r_bytes_left <= n_bytes_left;
            r_sum        <= n_sum;
            r_discarding <= n_discarding;
        end
    end

endmodule

// File: hw/rtl/sbf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sbf_cmd_fifo
// Small register queue of commands between front end and serializer.
// ----------------------------------------------------------------------------
module sbf_cmd_fifo
    import sbf_pkg::*;
#(
    parameter int DEPTH = FIFO_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: hw/rtl/sbf_back.sv
// ----------------------------------------------------------------------------
// sbf_back
// Walks one command byte by byte into the registered output stage.
// ----------------------------------------------------------------------------
module sbf_back
    import sbf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic       o_rejected
);

    logic       r_valid;
    logic [2:0] r_idx;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_rej;

    logic [2:0] last_idx;
    logic       ends_frame;
    logic       is_last;
    logic       load;
    logic [7:0] sel_byte;

    always_comb begin
        unique case (i_cmd.kind) inside
            K_PING, K_WHDR: last_idx = 3'd5;
            K_READ:         last_idx = 3'd7;
            K_WHDR_END:     last_idx = 3'd6;
            K_DATA_LAST:    last_idx = 3'd1;
            default:        last_idx = 3'd0;
        endcase
    end

    assign ends_frame = (i_cmd.kind != K_WHDR) && (i_cmd.kind != K_DATA);
    assign is_last    = (r_idx == last_idx);
    assign load       = !i_empty && (!r_valid || !i_out_stall);
    assign o_pop      = load && is_last;

    always_comb begin
        if (i_cmd.kind == K_REJECT) begin
            sel_byte = 8'h00;
        end else if (ends_frame && is_last) begin
            sel_byte = i_cmd.chk;
        end else if (i_cmd.kind == K_DATA || i_cmd.kind == K_DATA_LAST) begin
            sel_byte = i_cmd.p0;
        end else begin
            case (r_idx) inside
                3'd0, 3'd1: sel_byte = HDR_BYTE;
                3'd2:       sel_byte = i_cmd.id;
                3'd3:       sel_byte = i_cmd.len;
                3'd4:       sel_byte = i_cmd.inst;
                3'd5:       sel_byte = i_cmd.p0;
                default:    sel_byte = i_cmd.p1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= is_last ? 3'd0 : r_idx + 3'd1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_end  <= ends_frame && is_last;
            r_rej  <= (i_cmd.kind == K_REJECT);
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_end;
    assign o_rejected  = r_rej;

endmodule

// File: hw/rtl/sbf_checker.sv
// ----------------------------------------------------------------------------
// sbf_checker
// Port-level checks on the frame builder output, bound to the top level.
// ----------------------------------------------------------------------------
module sbf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_frame_end,
    input logic       o_rejected
);

    // rejection word is a lone zero byte that closes the run
    a_reject_word : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_rejected |-> o_frame_end && (o_out_byte == 8'h00))
        else $error("rejection word malformed");

    // a word right after a frame end starts a new frame or is a rejection
    a_frame_start : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_frame_end) ##1 o_out_valid
        |-> (o_out_byte == 8'hFF) || o_rejected)
        else $error("frame does not start with header byte");

    // output empty right after a reset edge
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled word holds
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
        && $stable(o_frame_end) && $stable(o_rejected))
        else $error("stalled output word changed");

endmodule

bind servo_command_frame_builder_top sbf_checker u_sbf_checker (.*);

// File: sim/servo_command_frame_builder_top_tb.sv
// ----------------------------------------------------------------------------
// servo_command_frame_builder_top_tb
// Self-checking bench for the servo frame builder. A behavioral copy of the
// frame rules predicts every output byte from each input word taken; a
// monitor compares the output bytes in order. Directed frames cover the
// field extremes, every opcode, zero-count and long writes, capacity
// rejection and swallowing. Random traffic then runs under several capacity
// settings, with or without random gaps on both sides.
// ----------------------------------------------------------------------------
module servo_command_frame_builder_top_tb;
    import sbf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 250;

    // one expected output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       rejected;
    } t_wire_byte;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [1:0] i_opcode     = OP_PING;
    logic [7:0] i_servo_id   = 8'h00;
    logic [7:0] i_reg_addr   = 8'h00;
    logic [7:0] i_byte_count = 8'h00;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_out_stall  = 1'b0;
    logic       i_cfg_valid  = 1'b0;
    logic [8:0] i_cfg_data   = 9'd0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_frame_end;
    logic       o_rejected;
    logic       o_cfg_ready;

    // frame state as the block should see it
    logic [8:0] frame_cap  = CAP_RESET;
    logic       write_open = 1'b0;
    logic       swallowing = 1'b0;
    logic [7:0] words_left = 8'd0;
    logic [7:0] write_sum  = 8'd0;

    t_wire_byte wire_q[$];
    int         frame_words_taken = 0;  // accepted words that produced bytes
    int         cycle_count       = 0;
    bit         failed            = 1'b0;

    // idle controls for the stimulus and the receiver
    bit         tx_idle_en = 1'b1;
    bit         rx_idle_en = 1'b1;
    int         hold_len   = 0;

    servo_command_frame_builder_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_servo_id   (i_servo_id),
        .i_reg_addr   (i_reg_addr),
        .i_byte_count (i_byte_count),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_frame_end  (o_frame_end),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------------
    function automatic void queue_wire_byte(input logic [7:0] b, input logic fin,
                                            input logic rej);
        t_wire_byte w;
        w.out_byte  = b;
        w.frame_end = fin;
        w.rejected  = rej;
        wire_q.push_back(w);
    endfunction

    // Expands one accepted input word into the bytes it puts on the wire.
    function automatic void build_frame_bytes(input logic [1:0] op, input logic [7:0] id,
                                              input logic [7:0] addr, input logic [7:0] cnt,
                                              input logic [7:0] data);
        logic [7:0] chk_sum;
        logic [7:0] len;
        int         n_prev;
        n_prev = wire_q.size();
        if (swallowing) begin
            // data words of a rejected write vanish
            words_left = words_left - 8'd1;
            if (words_left == 8'd0) swallowing = 1'b0;
        end else if (write_open) begin
            // any opcode counts as payload while a write is open
            queue_wire_byte(data, 1'b0, 1'b0);
            write_sum  = write_sum + data;
            words_left = words_left - 8'd1;
            if (words_left == 8'd0) begin
                queue_wire_byte(~write_sum, 1'b1, 1'b0);
                write_open = 1'b0;
            end
        end else begin
            case (op)
                OP_PING: begin
                    if ({1'b0, frame_cap} < SIZE_PING) begin
                        queue_wire_byte(8'h00, 1'b1, 1'b1);
                    end else begin
                        chk_sum = id + LEN_PING + INST_PING;
                        queue_wire_byte(HDR_BYTE, 1'b0, 1'b0);
                        queue_wire_byte(HDR_BYTE, 1'b0, 1'b0);
                        queue_wire_byte(id, 1'b0, 1'b0);
                        queue_wire_byte(LEN_PING, 1'b0, 1'b0);
                        queue_wire_byte(INST_PING, 1'b0, 1'b0);
                        queue_wire_byte(~chk_sum, 1'b1, 1'b0);
                    end
                end
                OP_READ: begin
                    if ({1'b0, frame_cap} < SIZE_READ) begin
                        queue_wire_byte(8'h00, 1'b1, 1'b1);
                    end else begin
                        chk_sum = id + LEN_READ + INST_READ + addr + cnt;
                        queue_wire_byte(HDR_BYTE, 1'b0, 1'b0);
                        queue_wire_byte(HDR_BYTE, 1'b0, 1'b0);
                        queue_wire_byte(id, 1'b0, 1'b0);
                        queue_wire_byte(LEN_READ, 1'b0, 1'b0);
                        queue_wire_byte(INST_READ, 1'b0, 1'b0);
                        queue_wire_byte(addr, 1'b0, 1'b0);
                        queue_wire_byte(cnt, 1'b0, 1'b0);
                        queue_wire_byte(~chk_sum, 1'b1, 1'b0);
                    end
                end
                OP_WRITE: begin
                    len = cnt + 8'd3;  // wraps for counts above 252
                    if ({1'b0, frame_cap} < SIZE_WRITE_MIN + {2'b00, cnt}) begin
                        queue_wire_byte(8'h00, 1'b1, 1'b1);
                        if (cnt != 8'd0) begin
                            swallowing = 1'b1;
                            words_left = cnt;
                        end
                    end else begin
                        queue_wire_byte(HDR_BYTE, 1'b0, 1'b0);
                        queue_wire_byte(HDR_BYTE, 1'b0, 1'b0);
                        queue_wire_byte(id, 1'b0, 1'b0);
                        queue_wire_byte(len, 1'b0, 1'b0);
                        queue_wire_byte(INST_WRITE, 1'b0, 1'b0);
                        queue_wire_byte(addr, 1'b0, 1'b0);
                        write_sum = id + len + INST_WRITE + addr;
                        if (cnt == 8'd0) begin
                            queue_wire_byte(~write_sum, 1'b1, 1'b0);
                        end else begin
                            write_open = 1'b1;
                            words_left = cnt;
                        end
                    end
                end
                default: ;  // OP_NONE while idle does nothing
            endcase
        end
        if (wire_q.size() > n_prev) frame_words_taken++;
    endfunction

    function automatic void check_wire_byte();
        t_wire_byte w;
        if (wire_q.size() == 0) begin
            $error("unexpected output word: out_byte 0x%02h frame_end %0b rejected %0b",
                   o_out_byte, o_frame_end, o_rejected);
            failed = 1'b1;
        end else begin
            w = wire_q.pop_front();
            if (o_out_byte !== w.out_byte) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", w.out_byte, o_out_byte);
                failed = 1'b1;
            end
            if (o_frame_end !== w.frame_end) begin
                $error("frame_end: expected %0b, got %0b", w.frame_end, o_frame_end);
                failed = 1'b1;
            end
            if (o_rejected !== w.rejected) begin
                $error("rejected: expected %0b, got %0b", w.rejected, o_rejected);
                failed = 1'b1;
            end
        end
    endfunction

    // Output check first, then the input word and the capacity write of the
    // same edge, so a byte never meets an expectation queued on that edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) check_wire_byte();
            if (i_in_valid && !o_in_stall)
                build_frame_bytes(i_opcode, i_servo_id, i_reg_addr, i_byte_count,
                                  i_data_byte);
            if (i_cfg_valid && o_cfg_ready) frame_cap = i_cfg_data;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------------
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
                i_out_stall <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("servo_command_frame_builder_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; every task returns just after a rising edge
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [1:0] op, input logic [7:0] id,
                             input logic [7:0] addr, input logic [7:0] cnt,
                             input logic [7:0] data);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_servo_id   <= id;
        i_reg_addr   <= addr;
        i_byte_count <= cnt;
        i_data_byte  <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // random gap after the word was taken
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // payload words with random opcode and content
    task automatic send_data_words(input int n);
        repeat (n)
            send_word(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      8'($urandom), 8'($urandom));
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        // let the monitor take in the last accepted word first
        @(posedge i_clk);
        while (wire_q.size() != 0) @(posedge i_clk);
        // extra settling time before the next step
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [8:0] cap);
        wait_for_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_ping_frames();
        send_word(OP_PING, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_PING, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_read_frames();
        send_word(OP_READ, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_word(OP_READ, 8'h01, 8'h24, 8'h02, 8'h5A);
    endtask

    task automatic test_write_frames();
        // zero count: header and checksum from one word
        send_word(OP_WRITE, 8'h5A, 8'h00, 8'h00, 8'hFF);
        // opcode is ignored on payload words
        send_word(OP_WRITE, 8'hFF, 8'hFF, 8'h03, 8'h00);
        send_word(OP_PING, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, 8'h11, 8'h22, 8'h33, 8'hFF);
        send_word(OP_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hA5);
    endtask

    task automatic test_idle_opcode();
        // unused opcode while idle gives nothing
        send_word(OP_NONE, 8'h3C, 8'hC3, 8'h7E, 8'h81);
        send_word(OP_PING, 8'h07, 8'h00, 8'h00, 8'h00);
    endtask

    task automatic test_capacity_reject();
        write_capacity(9'd0);  // everything is rejected
        send_word(OP_PING, 8'h01, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, 8'h01, 8'h10, 8'h04, 8'h00);
        send_word(OP_WRITE, 8'h01, 8'h10, 8'h00, 8'h00);
        send_word(OP_WRITE, 8'h01, 8'h10, 8'h02, 8'h00);
        send_data_words(2);    // swallowed
        write_capacity(9'd6);  // ping fits, read does not
        send_word(OP_PING, 8'h02, 8'h00, 8'h00, 8'h00);
        send_word(OP_READ, 8'h02, 8'h00, 8'h00, 8'h00);
        write_capacity(9'd7);
        send_word(OP_WRITE, 8'h03, 8'h20, 8'h00, 8'h00);
        send_word(OP_READ, 8'h03, 8'h20, 8'h01, 8'h00);
        write_capacity(9'd10); // write of 3 fits exactly, 4 does not
        send_word(OP_WRITE, 8'h04, 8'h30, 8'h03, 8'h00);
        send_data_words(3);
        send_word(OP_WRITE, 8'h04, 8'h30, 8'h04, 8'h00);
        send_data_words(4);
    endtask

    task automatic test_long_write();
        write_capacity(9'd261);  // write of 254 fits exactly, LEN wraps to 1
        send_word(OP_WRITE, 8'hFE, 8'h80, 8'hFE, 8'h00);
        send_data_words(254);
    endtask

    task automatic test_backpressure();
        write_capacity(CAP_RESET);
        tx_idle_en = 1'b0;
        hold_len   = HOLD_CYCLES;  // receiver holds off while reads pile up
        repeat (12)
            send_word(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        wait_for_drain();
        tx_idle_en = 1'b1;
    endtask

    task automatic send_random_frame();
        int pick;
        int cnt;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            send_word(OP_PING, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 45) begin
            send_word(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else if (pick < 93) begin
            // mostly short writes, a few long ones
            cnt = $urandom_range(0, 99);
            if (cnt < 70)
                cnt = $urandom_range(0, 6);
            else if (cnt < 98)
                cnt = $urandom_range(7, 24);
            else
                cnt = $urandom_range(25, 100);
            send_word(OP_WRITE, 8'($urandom), 8'($urandom), 8'(cnt), 8'($urandom));
            send_data_words(cnt);
        end else begin
            send_word(OP_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_traffic(input logic [8:0] cap, input int n_words,
                                       input bit idle);
        int start;
        write_capacity(cap);
        tx_idle_en = idle;
        rx_idle_en = idle;
        start = frame_words_taken;
        while (frame_words_taken - start < n_words) send_random_frame();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_ping_frames();
        test_read_frames();
        test_write_frames();
        test_idle_opcode();
        test_capacity_reject();
        test_long_write();
        test_backpressure();

        test_random_traffic(CAP_RESET, 20, 1'b1);
        test_random_traffic(9'($urandom_range(6, 40)), 15, 1'b1);
        test_random_traffic(9'd511, 15, 1'b0);
        test_random_traffic(9'd0, 5, 1'b1);
        test_random_traffic(9'($urandom_range(0, 511)), 15, 1'b1);
        test_random_traffic(CAP_RESET, 20, 1'b0);  // closing stretch, no gaps

        wait_for_drain();
        if (!failed && wire_q.size() == 0) begin
            $display("servo_command_frame_builder_top verification clean");
        end else begin
            $display("servo_command_frame_builder_top verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sbf_pkg.sv
hw/rtl/sbf_front.sv
hw/rtl/sbf_cmd_fifo.sv
hw/rtl/sbf_back.sv
hw/rtl/servo_command_frame_builder_top.sv
hw/rtl/sbf_checker.sv
sim/servo_command_frame_builder_top_tb.sv
